[src/sms_pkg.sv]
// shared types and codes for the sorted matrix staircase search block
`default_nettype none

package sms_pkg;

  // request kinds carried in req_type
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // size registers reset to a full 16 by 16 matrix
  localparam logic [4:0] SIZE_RESET = 5'd16;

  // one input item
  typedef struct packed {
    logic               req_type;
    logic [3:0]         load_row;
    logic [3:0]         load_col;
    logic signed [31:0] load_value;
    logic signed [31:0] search_key;
  } in_t;

  // one result item
  typedef struct packed {
    logic       found;
    logic [4:0] found_row;
    logic [4:0] found_col;
  } out_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // write one element
    logic init;   // latch key, start at top-right corner
    logic step;   // move one cell by the compare result
    logic push;   // load the result register
    logic hit;    // pushed result is a match
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;  // no rows or no columns in use
    logic eq;     // current element equals key
    logic lt;     // current element below key
    logic leave;  // next step would exit the matrix
  } stat_t;

endpackage

`default_nettype wire

[src/sorted_matrix_staircase_search.sv]
// top level of the sorted matrix staircase search block
`default_nettype none

// Holds a MAX_ROWS by MAX_COLS matrix of signed 32-bit elements whose rows and
// columns are sorted ascending; row_count and col_count (register indexes 0
// and 1) select the top-left part in use. A load item writes one element and
// gives no result. A search item walks from the top-right corner of the part
// in use, moving down on a smaller element and left on a larger one, and gives
// one result: found with the 1-based row and column, or all zeros. The walk
// reads one element per cycle from a single memory read port and visits at
// most rows + cols - 1 elements; an empty part in use gives all zeros without
// a walk. A finished walk also waits while an earlier result is still in the
// output register. The input is not ready again until the result sits in the
// output register, so the next transfer can be accepted as soon as it does; a
// result waiting there does not block further loads. A search that reads an
// element never loaded since reset returns an undefined result.
module sorted_matrix_staircase_search #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire sms_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output sms_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [4:0]   cfg_data
);

  sms_pkg::cmd_t  cmd;
  sms_pkg::stat_t stat;

  // walk sequencing and handshakes
  sms_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // matrix storage and compare
  sms_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/sms_datapath.sv]
// datapath: matrix memory, walk position, compare, size and result registers
`default_nettype none

module sms_datapath #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sms_pkg::in_t  in_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [4:0]    cfg_data,
  input  wire sms_pkg::cmd_t cmd,
  output sms_pkg::stat_t     stat,
  output sms_pkg::out_t      out_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = ADDR_W + 6;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r;
  logic [4:0]         row_count_r;
  logic [4:0]         col_count_r;
  logic [4:0]         rows_lim;
  logic [4:0]         cols_lim;
  logic [4:0]         pos_r_r, pos_r_nxt;
  logic [4:0]         pos_c_r, pos_c_nxt;
  logic signed [31:0] key_r;
  sms_pkg::out_t      out_data_r;
  logic [SUM_W-1:0]   rd_addr_wide;
  logic [SUM_W-1:0]   wr_addr_wide;
  logic               wr_in_range;
  logic [5:0]         row_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= sms_pkg::SIZE_RESET;
      col_count_r <= sms_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sms_pkg::CFG_ROW_COUNT) begin
        row_count_r <= cfg_data;
      end else begin
        col_count_r <= cfg_data;
      end
    end
  end

  // sizes above the physical matrix act as the physical size
  assign rows_lim = (32'(row_count_r) > MAX_ROWS) ? 5'(MAX_ROWS) : row_count_r;
  assign cols_lim = (32'(col_count_r) > MAX_COLS) ? 5'(MAX_COLS) : col_count_r;

  // compare the element just read against the key
  assign row_next   = 6'(pos_r_r) + 6'd1;
  assign stat.eq    = ($signed(rd_data_r) == key_r);
  assign stat.lt    = ($signed(rd_data_r) < key_r);
  assign stat.empty = (rows_lim == 5'd0) || (pos_c_r == 5'd0);
  assign stat.leave = stat.lt ? (row_next >= 6'(rows_lim)) : (pos_c_r == 5'd1);

  // next walk position: down on smaller, left on larger
  always_comb begin
    pos_r_nxt = pos_r_r;
    pos_c_nxt = pos_c_r;
    if (cmd.init) begin
      pos_r_nxt = 5'd0;
      pos_c_nxt = cols_lim;
    end else if (cmd.step) begin
      if (stat.lt) begin
        pos_r_nxt = row_next[4:0];
      end else begin
        pos_c_nxt = pos_c_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r_r <= pos_r_nxt;
    pos_c_r <= pos_c_nxt;
    if (cmd.init) begin
      key_r <= in_data.search_key;
    end
  end

  // row-major addresses; column position is kept plus one
  assign rd_addr_wide = SUM_W'(pos_r_nxt) * SUM_W'(MAX_COLS) + SUM_W'(pos_c_nxt)
                        - SUM_W'(1);
  assign wr_addr_wide = SUM_W'(in_data.load_row) * SUM_W'(MAX_COLS)
                        + SUM_W'(in_data.load_col);
  assign wr_in_range  = (32'(in_data.load_row) < MAX_ROWS)
                        && (32'(in_data.load_col) < MAX_COLS);

  // matrix memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && wr_in_range) begin
      mem[wr_addr_wide[ADDR_W-1:0]] <= in_data.load_value;
    end
    rd_data_r <= mem[rd_addr_wide[ADDR_W-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.found     <= cmd.hit;
      out_data_r.found_row <= cmd.hit ? (pos_r_r + 5'd1) : 5'd0;
      out_data_r.found_col <= cmd.hit ? pos_c_r : 5'd0;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

[src/sms_ctrl.sv]
// controller: sequences loads and the staircase walk, owns the handshakes
`default_nettype none

module sms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_req_type,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire sms_pkg::stat_t stat,
  output sms_pkg::cmd_t       cmd
);

  sms_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_xfer;
  logic            slot_free;

  assign in_ready  = (state_r == sms_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sms_pkg::ST_IDLE: begin
        if (in_xfer && in_req_type == sms_pkg::REQ_SEARCH) begin
          state_nxt = sms_pkg::ST_PRIME;
        end
      end
      sms_pkg::ST_PRIME: begin
        if (!stat.empty) begin
          state_nxt = sms_pkg::ST_WALK;
        end else if (slot_free) begin
          state_nxt = sms_pkg::ST_IDLE;
        end
      end
      sms_pkg::ST_WALK: begin
        if ((stat.eq || stat.leave) && slot_free) begin
          state_nxt = sms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sms_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      sms_pkg::ST_IDLE: begin
        cmd.load = in_xfer && (in_req_type == sms_pkg::REQ_LOAD);
        cmd.init = in_xfer && (in_req_type == sms_pkg::REQ_SEARCH);
      end
      sms_pkg::ST_PRIME: begin
        cmd.push = stat.empty && slot_free;
      end
      sms_pkg::ST_WALK: begin
        if (stat.eq || stat.leave) begin
          cmd.push = slot_free;
          cmd.hit  = stat.eq;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sms_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a result never overwrites one that is still waiting
  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over a pending result");

  // a new result only appears from a search in progress
  a_valid_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r != sms_pkg::ST_IDLE))
    else $error("result appeared without a search");

  // an accepted search always primes the first read
  a_search_primes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type == sms_pkg::REQ_SEARCH) |=> (state_r == sms_pkg::ST_PRIME))
    else $error("accepted search did not start a walk");

  // the walk only steps while no result is due
  a_step_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!cmd.push && state_r == sms_pkg::ST_WALK && !stat.eq))
    else $error("walk stepped past a finished search");
`endif

endmodule

`default_nettype wire
